/* src/jet_pkg.sv */
// ---------------------------------------------------------------------------
// jet_pkg
// Shared types and constants for the Julia escape-time core.
// ---------------------------------------------------------------------------
package jet_pkg;

	localparam int COORD_W   = 32;  // coordinate word, signed fixed point
	localparam int COUNT_W   = 16;  // iteration count / limit
	localparam int CFG_IDX_W = 2;   // register index on the config channel
	localparam int PROD_W    = 64;  // exact product of two coordinates
	localparam int RND_W     = 34;  // rounded square terms while z is bounded

	localparam logic [COUNT_W-1:0] LIMIT_RESET = 16'd500;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_C_REAL     = 2'd0,
		CFG_C_IMAG     = 2'd1,
		CFG_ITER_LIMIT = 2'd2
	} cfg_idx_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // take the start point, clear the count
		logic mul;       // register zr*zr, zi*zi, zr*zi
		logic chk;       // register rounded real/imag terms
		logic upd;       // add c, saturate, bump the count
		logic out_load;  // capture count and escape flag
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic escape;    // |z|^2 >= 4
		logic at_limit;  // count has reached the limit
	} dp_stat_t;

endpackage

/* src/jet_ifs.sv */
// ---------------------------------------------------------------------------
// jet_ifs
// Valid/ready channel interfaces for the Julia escape-time core.
// ---------------------------------------------------------------------------
interface jet_in_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [jet_pkg::COORD_W-1:0]    start_real;
	logic signed [jet_pkg::COORD_W-1:0]    start_imag;

	modport source(output valid, start_real, start_imag, input ready);
	modport sink(input valid, start_real, start_imag, output ready);
endinterface

interface jet_out_if;
	logic                          valid;
	logic                          ready;
	logic [jet_pkg::COUNT_W-1:0]   iteration_count;
	logic                          escaped;

	modport source(output valid, iteration_count, escaped, input ready);
	modport sink(input valid, iteration_count, escaped, output ready);
endinterface

interface jet_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [jet_pkg::CFG_IDX_W-1:0]   index;
	logic [jet_pkg::COORD_W-1:0]     data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

/* src/jet_dp.sv */
// ---------------------------------------------------------------------------
// jet_dp
// Datapath: z register, three product registers, rounding, c add with
// saturation, iteration counter and result register.
// ---------------------------------------------------------------------------
module jet_dp #(
	parameter int FRAC_BITS = 24
) (
	input  logic                                  clk,
	input  jet_pkg::dp_cmd_t                      cmd,
	output jet_pkg::dp_stat_t                     stat,
	input  logic signed [jet_pkg::COORD_W-1:0]    start_real,
	input  logic signed [jet_pkg::COORD_W-1:0]    start_imag,
	input  logic signed [jet_pkg::COORD_W-1:0]    c_real,
	input  logic signed [jet_pkg::COORD_W-1:0]    c_imag,
	input  logic [jet_pkg::COUNT_W-1:0]           limit,
	output logic [jet_pkg::COUNT_W-1:0]           res_count,
	output logic                                  res_escaped
);

	localparam int CW = jet_pkg::COORD_W;
	localparam int PW = jet_pkg::PROD_W;
	localparam int RW = jet_pkg::RND_W;
	localparam int SW = PW + 2;  // room for difference/doubling plus half

	localparam logic [PW:0]         FOUR = (PW+1)'(1) << (2*FRAC_BITS + 2);
	localparam logic signed [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);
	localparam logic signed [RW:0]  SAT_MAX = (RW+1)'({1'b0, {(CW-1){1'b1}}});
	localparam logic signed [RW:0]  SAT_MIN = -(RW+1)'({1'b0, {(CW-1){1'b1}}}) - 1;

	logic signed [CW-1:0]   zr_q, zi_q;
	logic signed [PW-1:0]   rr_q, ii_q, ri_q;
	logic signed [RW-1:0]   nr_rnd_q, ni_rnd_q;
	logic [jet_pkg::COUNT_W-1:0] count_q;
	logic [jet_pkg::COUNT_W-1:0] res_count_q;
	logic                   res_esc_q;

	logic [PW:0]            mag;
	logic signed [SW-1:0]   re_sum, im_sum, re_shr, im_shr;
	logic signed [RW:0]     re_new, im_new;
	logic signed [CW-1:0]   re_sat, im_sat;

	// |z|^2 from the exact squares; both terms are non-negative
	assign mag = {1'b0, rr_q} + {1'b0, ii_q};
	assign stat.escape   = (mag >= FOUR);
	assign stat.at_limit = (count_q >= limit);

	// round to nearest, ties up: add half, then floor
	assign re_sum = SW'(rr_q) - SW'(ii_q) + HALF;
	assign im_sum = (SW'(ri_q) <<< 1) + HALF;
	assign re_shr = re_sum >>> FRAC_BITS;
	assign im_shr = im_sum >>> FRAC_BITS;

	assign re_new = (RW+1)'(nr_rnd_q) + (RW+1)'(c_real);
	assign im_new = (RW+1)'(ni_rnd_q) + (RW+1)'(c_imag);

	always_comb begin
		if (re_new > SAT_MAX) begin
			re_sat = SAT_MAX[CW-1:0];
		end else if (re_new < SAT_MIN) begin
			re_sat = SAT_MIN[CW-1:0];
		end else begin
			re_sat = re_new[CW-1:0];
		end
		if (im_new > SAT_MAX) begin
			im_sat = SAT_MAX[CW-1:0];
		end else if (im_new < SAT_MIN) begin
			im_sat = SAT_MIN[CW-1:0];
		end else begin
			im_sat = im_new[CW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			zr_q    <= start_real;
			zi_q    <= start_imag;
			count_q <= '0;
		end else if (cmd.upd) begin
			zr_q    <= re_sat;
			zi_q    <= im_sat;
			count_q <= count_q + 1'b1;
		end
		if (cmd.mul) begin
			rr_q <= PW'(zr_q) * PW'(zr_q);
			ii_q <= PW'(zi_q) * PW'(zi_q);
			ri_q <= PW'(zr_q) * PW'(zi_q);
		end
		// only meaningful while |z| < 2, where the terms fit RND_W bits
		if (cmd.chk) begin
			nr_rnd_q <= re_shr[RW-1:0];
			ni_rnd_q <= im_shr[RW-1:0];
		end
		if (cmd.out_load) begin
			res_count_q <= count_q;
			res_esc_q   <= stat.escape;
		end
	end

	assign res_count   = res_count_q;
	assign res_escaped = res_esc_q;

endmodule

/* src/jet_ctrl.sv */
// ---------------------------------------------------------------------------
// jet_ctrl
// Sequencer: one iteration is multiply, check/round, update.
// ---------------------------------------------------------------------------
module jet_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  jet_pkg::dp_stat_t  stat,
	output jet_pkg::dp_cmd_t   cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_CHK,
		ST_UPD
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   finish;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;
	assign finish    = (state_q == ST_CHK) && (stat.escape || stat.at_limit);

	always_comb begin
		cmd          = '0;
		cmd.load     = in_ready && in_valid;
		cmd.mul      = (state_q == ST_MUL);
		cmd.chk      = (state_q == ST_CHK);
		cmd.upd      = (state_q == ST_UPD);
		cmd.out_load = finish && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (!finish) begin
						state_q <= ST_UPD;
					end else if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_UPD: begin
					state_q <= ST_MUL;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* src/julia_escape_time_core.sv */
// ---------------------------------------------------------------------------
// julia_escape_time_core
// Julia set escape-time counter: iterates z = z*z + c from a start point
// until |z|^2 >= 4 or the iteration limit, then reports count and escape.
// ---------------------------------------------------------------------------
//
//  channel | dir | payload                          | transaction when
//  --------+-----+----------------------------------+-------------------
//  in_ch   | in  | start_real, start_imag (Q.24)    | valid && ready
//  out_ch  | out | iteration_count, escaped         | valid && ready
//  cfg     | in  | index (0 c_real, 1 c_imag,       | valid && ready
//          |     |  2 iteration_limit), data        |  (ready tied high)
//
// One point at a time. Each iteration steps through multiply, round and
// update on the shared path. The result sits in an output register; a
// new point is accepted while it waits, and the sequencer only holds in
// its check step if the previous result is still not taken when the next
// one is ready.
// Reset is asynchronous, active low: c = 0, limit = 500, no result pending.
//
module julia_escape_time_core #(
	parameter int FRAC_BITS = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	jet_in_if.sink        in_ch,
	jet_out_if.source     out_ch,
	jet_cfg_if.sink       cfg
);

	logic signed [jet_pkg::COORD_W-1:0] c_real_q;
	logic signed [jet_pkg::COORD_W-1:0] c_imag_q;
	logic [jet_pkg::COUNT_W-1:0]        limit_q;

	jet_pkg::dp_cmd_t  cmd;
	jet_pkg::dp_stat_t stat;

	// Config is always accepted; write it only while idle (not enforced here).
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_real_q <= '0;
			c_imag_q <= '0;
			limit_q  <= jet_pkg::LIMIT_RESET;
		end else if (cfg.valid) begin
			unique case (jet_pkg::cfg_idx_t'(cfg.index))
				jet_pkg::CFG_C_REAL:     c_real_q <= cfg.data;
				jet_pkg::CFG_C_IMAG:     c_imag_q <= cfg.data;
				jet_pkg::CFG_ITER_LIMIT: limit_q  <= cfg.data[jet_pkg::COUNT_W-1:0];
				default: begin
					// index past the register list: ignored
				end
			endcase
		end
	end

	// Sequencer: owns the point and result handshakes and the output valid flag.
	jet_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Datapath: three 32x32 products per iteration, all registered.
	jet_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk         (clk),
		.cmd         (cmd),
		.stat        (stat),
		.start_real  (in_ch.start_real),
		.start_imag  (in_ch.start_imag),
		.c_real      (c_real_q),
		.c_imag      (c_imag_q),
		.limit       (limit_q),
		.res_count   (out_ch.iteration_count),
		.res_escaped (out_ch.escaped)
	);

endmodule

/* src/jet_checker.sv */
// ---------------------------------------------------------------------------
// jet_checker
// Port-level checks for the Julia escape-time core, bound to the top level.
// ---------------------------------------------------------------------------
module jet_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic [jet_pkg::COUNT_W-1:0]  iteration_count,
	input  logic                         escaped,
	input  logic                         cfg_ready
);

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(iteration_count) && $stable(escaped))
		else $error("result changed while stalled");

	// one point at a time: busy right after a transaction
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a point is in flight");

	// a new result only appears from a busy core
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without a point in flight");

	// config port never back-pressures
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("config channel not ready");

endmodule

bind julia_escape_time_core jet_checker u_jet_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_ch.valid),
	.in_ready        (in_ch.ready),
	.out_valid       (out_ch.valid),
	.out_ready       (out_ch.ready),
	.iteration_count (out_ch.iteration_count),
	.escaped         (out_ch.escaped),
	.cfg_ready       (cfg.ready)
);

/* sim/julia_escape_time_checker.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// julia_escape_time_checker
// Watches the config, point and result channels of the Julia escape-time
// core, predicts count and escape flag per point, and compares in order.
// ---------------------------------------------------------------------------
module julia_escape_time_checker
	import jet_pkg::*;
#(
	parameter int FRAC_BITS = 24
) (
	input  logic  clk,
	input  logic  arst_n,
	jet_in_if     in_ch,
	jet_out_if    out_ch,
	jet_cfg_if    cfg_ch,
	output int    fail_count,
	output int    open_count
);

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic               escaped;
	} escape_result_t;

	localparam longint unsigned FOUR_FX = 64'd4 << (2 * FRAC_BITS);
	localparam longint          CO_MAX  = 64'sd2147483647;
	localparam longint          CO_MIN  = -64'sd2147483648;

	// shadow of the core's registers
	longint         c_re;
	longint         c_im;
	int unsigned    iter_max;

	escape_result_t escape_fifo[$];
	int             fails;

	function automatic longint unsigned mag_sq(input longint re, input longint im);
		longint unsigned ar;
		longint unsigned ai;
		ar = (re < 0) ? -re : re;
		ai = (im < 0) ? -im : im;
		return ar * ar + ai * ai;
	endfunction

	// drop FRAC_BITS, nearest, ties toward +inf
	function automatic longint round_fx(input longint v);
		return (v + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
	endfunction

	function automatic longint clamp32(input longint v);
		if (v > CO_MAX)
			return CO_MAX;
		if (v < CO_MIN)
			return CO_MIN;
		return v;
	endfunction

	function automatic escape_result_t iterate_point(input logic signed [COORD_W-1:0] re0,
			input logic signed [COORD_W-1:0] im0);
		longint          zr;
		longint          zi;
		longint          rr;
		longint          ii;
		longint          ri;
		longint unsigned mag;
		int unsigned     n;
		escape_result_t  res;
		zr  = re0;
		zi  = im0;
		n   = 0;
		mag = mag_sq(zr, zi);
		// inside the loop |zr|, |zi| < 2.0, so the products fit easily
		while (n < iter_max && mag < FOUR_FX) begin
			rr  = zr * zr;
			ii  = zi * zi;
			ri  = zr * zi;
			zr  = clamp32(round_fx(rr - ii) + c_re);
			zi  = clamp32(round_fx(2 * ri) + c_im);
			n++;
			mag = mag_sq(zr, zi);
		end
		res.count   = n[COUNT_W-1:0];
		res.escaped = (mag >= FOUR_FX);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		escape_result_t want;
		if (!arst_n) begin
			c_re     = 0;
			c_im     = 0;
			iter_max = LIMIT_RESET;
			escape_fifo.delete();
			fails    = 0;
			fail_count <= 0;
			open_count <= 0;
		end else begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_idx_t'(cfg_ch.index))
					CFG_C_REAL:     c_re = longint'($signed(cfg_ch.data));
					CFG_C_IMAG:     c_im = longint'($signed(cfg_ch.data));
					CFG_ITER_LIMIT: iter_max = cfg_ch.data[COUNT_W-1:0];
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready)
				escape_fifo.push_back(iterate_point(in_ch.start_real, in_ch.start_imag));
			if (out_ch.valid && out_ch.ready) begin
				if (escape_fifo.size() == 0) begin
					$error("result transaction with no point outstanding: count %0d escaped %0b",
						out_ch.iteration_count, out_ch.escaped);
					fails++;
				end else begin
					want = escape_fifo.pop_front();
					if (out_ch.iteration_count !== want.count) begin
						$error("iteration_count: expected %0d, got %0d",
							want.count, out_ch.iteration_count);
						fails++;
					end
					if (out_ch.escaped !== want.escaped) begin
						$error("escaped: expected %0b, got %0b", want.escaped, out_ch.escaped);
						fails++;
					end
				end
			end
			fail_count <= fails;
			open_count <= escape_fifo.size();
		end
	end

endmodule

/* sim/julia_escape_time_core_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// julia_escape_time_core_tb
// Drives start points and register writes into the Julia escape-time core,
// stalls the result side at random, and lets the checker score each result.
// ---------------------------------------------------------------------------
module julia_escape_time_core_tb;
	import jet_pkg::*;

	localparam int FRAC_BITS = 24;
	localparam int Q_ONE     = 1 << FRAC_BITS;   // 1.0 in Q7.24

	localparam logic signed [COORD_W-1:0] CO_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [COORD_W-1:0] CO_MIN = 32'sh8000_0000;

	// Slowest correct run: one point bounded at limit 65535, about 1200
	// points at limits up to 48, 25 points at limit 500, the long receiver
	// hold-off and random stalls. LIMIT_CYCLES sits well above all of that.
	localparam int LIMIT_CYCLES = 2_500_000;
	localparam int HOLD_CYCLES  = 600;   // receiver hold-off, fills the core
	localparam int SETTLE       = 16;    // quiet cycles before the verdict
	localparam int N_PHASES     = 12;

	logic clk = 1'b0;
	logic arst_n;

	jet_in_if  in_ch();
	jet_out_if out_ch();
	jet_cfg_if cfg_ch();

	int   chk_fails;
	int   chk_open;
	int   cycle_count = 0;

	// idle control shared by the stimulus and result sides
	logic no_gaps    = 1'b0;
	logic hold_armed = 1'b0;
	logic hold_done  = 1'b0;

	always #10 clk = ~clk;

	julia_escape_time_core #(
		.FRAC_BITS(FRAC_BITS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch),
		.out_ch(out_ch),
		.cfg   (cfg_ch)
	);

	julia_escape_time_checker #(
		.FRAC_BITS(FRAC_BITS)
	) chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_ch    (cfg_ch),
		.fail_count(chk_fails),
		.open_count(chk_open)
	);

	// Watchdog: a hang anywhere ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Result side: ready drops in about a quarter of the cycles, never while
	// no_gaps is set. Once armed, one long hold-off lets the core back up
	// while points keep coming.
	initial begin : result_sink
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_armed && !hold_done) begin
				hold_done = 1'b1;
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_ch.ready <= no_gaps || ($urandom_range(99) >= 24);
				@(posedge clk);
			end
		end
	end

	// One point transaction; unless no_gaps is set, an idle gap goes in
	// front of about a quarter of them.
	task automatic send_point(input logic signed [COORD_W-1:0] re,
			input logic signed [COORD_W-1:0] im);
		if (!no_gaps && $urandom_range(99) < 24) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.start_real <= re;
		in_ch.start_imag <= im;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [COORD_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	// Writes all three registers; only called with the core idle.
	task automatic load_setting(input logic signed [COORD_W-1:0] cr,
			input logic signed [COORD_W-1:0] ci, input logic [COUNT_W-1:0] lim);
		write_reg(CFG_C_REAL, cr);
		write_reg(CFG_C_IMAG, ci);
		write_reg(CFG_ITER_LIMIT, {{(COORD_W-COUNT_W){1'b0}}, lim});
		cfg_ch.valid <= 1'b0;
	endtask

	// Stop offering and wait until every point has its result back. The
	// open count is updated at the edge after an accept, hence do-while.
	task automatic drain();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (chk_open != 0);
	endtask

	// Julia constant: mostly the interesting band |c| <= 1, some raw words,
	// some extremes.
	function automatic logic signed [COORD_W-1:0] pick_c();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 70)
			return int'($urandom_range(2 * Q_ONE, 0)) - Q_ONE;
		if (r < 85)
			return $urandom;
		case ($urandom_range(3, 0))
			0:       return CO_MAX;
			1:       return CO_MIN;
			2:       return '0;
			default: return 2 * Q_ONE;
		endcase
	endfunction

	// Start coordinate: near the origin for long orbits, within +/-2.0 for
	// most, raw 32-bit words for the rest (most of those escape at once).
	function automatic logic signed [COORD_W-1:0] pick_coord();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 20)
			return int'($urandom_range(Q_ONE, 0)) - Q_ONE / 2;
		if (r < 75)
			return int'($urandom_range(4 * Q_ONE, 0)) - 2 * Q_ONE;
		return $urandom;
	endfunction

	initial begin : stimulus
		logic [COUNT_W-1:0] lim;
		int                 n_pts;

		arst_n           = 1'b0;
		in_ch.valid      = 1'b0;
		in_ch.start_real = '0;
		in_ch.start_imag = '0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.index     = CFG_C_REAL;
		cfg_ch.data      = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset setting, c = 0, limit 500: origin and 1.0 stay bounded,
		// extremes and the |z0| = 2 boundary give count 0, 1.5 escapes at 1.
		send_point(0, 0);
		send_point(CO_MAX, CO_MAX);
		send_point(CO_MIN, CO_MIN);
		send_point(2 * Q_ONE, 0);
		send_point(0, -2 * Q_ONE);
		send_point(Q_ONE * 3 / 2, 0);
		send_point(Q_ONE, 0);

		// Extreme c, limit 1: escape on the only allowed iteration; the real
		// part saturates high, the imaginary part saturates low.
		drain();
		load_setting(CO_MAX, CO_MIN, 16'd1);
		send_point(0, 0);
		send_point(Q_ONE * 19 / 10, 0);
		send_point(Q_ONE * 14 / 10, -(Q_ONE * 14 / 10));
		send_point(-(Q_ONE * 19 / 10), Q_ONE * 3 / 10);

		// Opposite extremes: real saturates low, imaginary saturates high.
		drain();
		load_setting(CO_MIN, CO_MAX, 16'd3);
		send_point(0, Q_ONE * 19 / 10);
		send_point(Q_ONE * 14 / 10, Q_ONE * 14 / 10);
		send_point(0, 0);

		// c = 2.0, limit 1: the origin lands exactly on |z|^2 = 4.
		drain();
		load_setting(2 * Q_ONE, 0, 16'd1);
		send_point(0, 0);
		send_point(Q_ONE / 2, 0);

		// Zero limit: no iteration, escape only if already outside.
		drain();
		load_setting(0, 0, 16'd0);
		send_point(0, 0);
		send_point(2 * Q_ONE, 0);

		// Largest limit: one orbit that never escapes, plus quick ones.
		drain();
		load_setting(0, 0, 16'hFFFF);
		send_point(0, 0);
		send_point(Q_ONE * 12 / 10, 0);
		send_point(CO_MIN, CO_MAX);

		// Random phases. Small limits keep the run short; phase 3 uses the
		// default limit, phase 9 the minimum. Phase 1 arms the hold-off,
		// phase 5 runs with no idling on either side.
		for (int ph = 0; ph < N_PHASES; ph++) begin
			if (ph == 3)
				lim = LIMIT_RESET;
			else if (ph == 9)
				lim = 16'd1;
			else
				lim = COUNT_W'($urandom_range(48, 1));
			n_pts = (ph == 3) ? 25 : 105;
			drain();
			load_setting(pick_c(), pick_c(), lim);
			if (ph == 1)
				hold_armed <= 1'b1;
			no_gaps <= (ph == 5);
			repeat (n_pts) send_point(pick_coord(), pick_coord());
		end

		drain();
		repeat (SETTLE) @(posedge clk);
		if (chk_fails == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
